/* hdl/fcw_pkg.sv */
// ----------------------------------------------------------------------------
// fcw_pkg
// Types and codes shared by the FAT12 cluster chain walker files.
// ----------------------------------------------------------------------------
package fcw_pkg;

    // Field widths fixed by the item format
    localparam int OP_W       = 2;
    localparam int INDEX_W    = 13;
    localparam int CLUSTER_W  = 12;
    localparam int LENGTH_W   = 32;
    localparam int ADDR_W     = 33;
    localparam int EXTENT_W   = 17;
    localparam int BASE_W     = 32;
    localparam int PRODUCT_W  = EXTENT_W + CLUSTER_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DATA_START = 1'b0;
    localparam logic CFG_CLUSTER    = 1'b1;

    // Cluster marks
    localparam logic [CLUSTER_W-1:0] CLUSTER_EOC_MIN = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] CLUSTER_BAD     = 12'hFF7;
    localparam logic [CLUSTER_W-1:0] CLUSTER_END     = 12'hFFF;

    // Largest usable cluster size
    localparam logic [EXTENT_W-1:0] CLUSTER_BYTES_MAX = 17'h10000;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [INDEX_W-1:0]   table_index;
        logic [7:0]           table_byte;
        logic [CLUSTER_W-1:0] start_cluster;
        logic [LENGTH_W-1:0]  file_length;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   extent_address;
        logic [EXTENT_W-1:0] extent_length;
        logic                last;
        logic [1:0]          status;
    } out_item_t;

endpackage

/* hdl/fcw_channels.sv */
// ----------------------------------------------------------------------------
// fcw channels
// Valid/ready channels for command items and extent items.
// ----------------------------------------------------------------------------
interface fcw_in_if;
    logic              valid;
    logic              ready;
    fcw_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcw_out_if;
    logic               valid;
    logic               ready;
    fcw_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fcw_fat_ram.sv */
// ----------------------------------------------------------------------------
// fcw_fat_ram
// Packed FAT byte store: one write port, one registered read port. Reads
// beyond the table return zero.
// ----------------------------------------------------------------------------
module fcw_fat_ram #(
    parameter int DEPTH = 6144
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [fcw_pkg::INDEX_W-1:0]     waddr,
    input  logic [7:0]                      wdata,
    input  logic [fcw_pkg::INDEX_W-1:0]     raddr,
    output logic [7:0]                      rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;
    logic       rd_in_range_reg;
    logic       wr_in_range;
    logic       rd_in_range;

    assign wr_in_range = 32'(waddr) < DEPTH;
    assign rd_in_range = 32'(raddr) < DEPTH;

    // Write a loaded byte; drop loads beyond the table
    always_ff @(posedge clk)
    begin
        if (we && wr_in_range)
        begin
            mem[waddr[AW-1:0]] <= wdata;
        end
    end

    // Read one byte a cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg     <= mem[raddr[AW-1:0]];
        rd_in_range_reg <= rd_in_range;
    end

    assign rdata = rd_in_range_reg ? rd_data_reg : 8'h00;

endmodule

/* hdl/fcw_addr_unit.sv */
// ----------------------------------------------------------------------------
// fcw_addr_unit
// Extent address unit: multiply cluster size by cluster index, then add the
// data region base. The product and the sum are each registered.
// ----------------------------------------------------------------------------
module fcw_addr_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [fcw_pkg::EXTENT_W-1:0]      cluster_bytes,
    input  logic [fcw_pkg::CLUSTER_W-1:0]     cluster_index,
    input  logic [fcw_pkg::BASE_W-1:0]        base,
    output logic [fcw_pkg::ADDR_W-1:0]        address
);
    logic [fcw_pkg::PRODUCT_W-1:0] product_reg;
    logic [fcw_pkg::BASE_W-1:0]    base_reg;
    logic [fcw_pkg::ADDR_W-1:0]    address_reg;
    logic                          add_pending_reg;

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            product_reg <= cluster_bytes * cluster_index;
            base_reg    <= base;
        end
    end

    // Track the add that follows a multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_pending_reg <= 1'b0;
        end
        else
        begin
            add_pending_reg <= start;
        end
    end

    // Add stage
    always_ff @(posedge clk)
    begin
        if (add_pending_reg)
        begin
            address_reg <= fcw_pkg::ADDR_W'(base_reg) + fcw_pkg::ADDR_W'(product_reg);
        end
    end

    assign address = address_reg;

endmodule

/* hdl/fat12_cluster_chain_walker_core.sv */
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// Walks a FAT12 cluster chain held in a loaded byte table and emits extents.
// ----------------------------------------------------------------------------
// Usage:
//   items   : command items (load table byte, start chain, step).
//   extents : one result item per step, none for loads and starts.
//   cfg_*   : register writes, taken only while the block is idle as the user's duty; the block has no check.
// A step that finds the chain finished or a bad cluster presents its
// extent in the cycle after it is accepted. A step on a live cluster
// passes through ST_RD_LO, ST_RD_HI and ST_FIN before its extent is
// registered: two reads of the single table read port, then the unpack
// of the next entry; the multiply and the add of the address unit
// overlap the reads. With the receiver ready, loads and starts are
// taken every cycle.
// The block works on one item at a time; items.ready stays low while a step
// is in work and while an extent waits to be taken, so a stalled receiver
// holds off the next item.
// Reset returns the chain to the finished state, with data region start 0
// and a cluster size of 512 bytes. The byte table is not cleared: every
// table byte a walk reads must be loaded first.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_core #(
    parameter int FAT_BYTES = 6144
) (
    input  logic         clk,
    input  logic         rst_n,
    fcw_in_if.sink       items,
    fcw_out_if.source    extents,
    input  logic         cfg_write,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RD_LO = 4'b0010,
        ST_RD_HI = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [fcw_pkg::BASE_W-1:0]    data_start_reg;
    logic [fcw_pkg::EXTENT_W-1:0]  cluster_bytes_reg;
    logic [fcw_pkg::CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic [fcw_pkg::LENGTH_W-1:0]  remaining_reg, remaining_next;
    logic [fcw_pkg::INDEX_W-1:0]   offset_reg;
    logic                          odd_reg;
    logic [7:0]                    low_byte_reg;
    logic [fcw_pkg::EXTENT_W-1:0]  length_reg;
    logic                          out_valid_reg, out_valid_next;
    fcw_pkg::out_item_t            out_item_reg, out_item_next;

    logic                          accept;
    logic                          step_live;
    logic [fcw_pkg::EXTENT_W-1:0]  cluster_bytes;
    logic [fcw_pkg::EXTENT_W-1:0]  length;
    logic [fcw_pkg::INDEX_W-1:0]   offset;
    logic [fcw_pkg::INDEX_W-1:0]   rd_addr;
    logic [7:0]                    rd_data;
    logic [fcw_pkg::CLUSTER_W-1:0] next_cluster;
    logic [fcw_pkg::ADDR_W-1:0]    address;
    logic                          cur_done;
    logic                          cur_bad;
    logic                          next_ends;

    assign items.ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept        = items.valid && items.ready;
    assign extents.valid = out_valid_reg;
    assign extents.data  = out_item_reg;

    // Classify the current cluster
    assign cur_done = (remaining_reg == '0) || (cluster_reg >= fcw_pkg::CLUSTER_EOC_MIN);
    assign cur_bad  = (cluster_reg < 12'd2) || (cluster_reg == fcw_pkg::CLUSTER_BAD);
    assign step_live = accept && (items.data.op == fcw_pkg::OP_STEP) && !cur_done && !cur_bad;

    // Clamp the cluster size and size this extent
    assign cluster_bytes = (cluster_bytes_reg > fcw_pkg::CLUSTER_BYTES_MAX)
                         ? fcw_pkg::CLUSTER_BYTES_MAX : cluster_bytes_reg;
    assign length = (fcw_pkg::LENGTH_W'(cluster_bytes) < remaining_reg)
                  ? cluster_bytes : remaining_reg[fcw_pkg::EXTENT_W-1:0];

    // Byte offset of the entry: cluster * 3 / 2
    assign offset = fcw_pkg::INDEX_W'(cluster_reg) + fcw_pkg::INDEX_W'(cluster_reg[11:1]);

    // Unpack the next entry from the two table bytes
    assign next_cluster = odd_reg ? {rd_data, low_byte_reg[7:4]}
                                  : {rd_data[3:0], low_byte_reg};
    assign next_ends = (remaining_reg == '0)
                    || (next_cluster >= fcw_pkg::CLUSTER_EOC_MIN)
                    || (next_cluster < 12'd2)
                    || (next_cluster == fcw_pkg::CLUSTER_BAD);

    // Select the table read address
    always_comb
    begin
        rd_addr = offset_reg;
        if (state_reg == ST_RD_HI)
        begin
            rd_addr = offset_reg + 13'd1;
        end
    end

    fcw_fat_ram #(
        .DEPTH (FAT_BYTES)
    ) u_fat_ram (
        .clk   (clk),
        .we    (accept && (items.data.op == fcw_pkg::OP_LOAD)),
        .waddr (items.data.table_index),
        .wdata (items.data.table_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    fcw_addr_unit u_addr_unit (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (step_live),
        .cluster_bytes (cluster_bytes),
        .cluster_index (cluster_reg - 12'd2),
        .base          (data_start_reg),
        .address       (address)
    );

    // Sequencer and chain state
    always_comb
    begin
        state_next     = state_reg;
        cluster_next   = cluster_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && extents.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (items.data.op)
                        fcw_pkg::OP_START:
                        begin
                            cluster_next   = items.data.start_cluster;
                            remaining_next = items.data.file_length;
                        end
                        fcw_pkg::OP_STEP:
                        begin
                            out_item_next.extent_address = '0;
                            out_item_next.extent_length  = '0;
                            if (cur_done)
                            begin
                                out_item_next.last   = 1'b0;
                                out_item_next.status = fcw_pkg::STATUS_DONE;
                                out_valid_next       = 1'b1;
                            end
                            else if (cur_bad)
                            begin
                                out_item_next.last   = 1'b1;
                                out_item_next.status = fcw_pkg::STATUS_BAD;
                                out_valid_next       = 1'b1;
                                cluster_next         = fcw_pkg::CLUSTER_END;
                                remaining_next       = '0;
                            end
                            else
                            begin
                                remaining_next = remaining_reg
                                               - fcw_pkg::LENGTH_W'(length);
                                state_next     = ST_RD_LO;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cluster_next                 = next_cluster;
                out_item_next.extent_address = address;
                out_item_next.extent_length  = length_reg;
                out_item_next.last           = next_ends;
                out_item_next.status         = fcw_pkg::STATUS_OK;
                out_valid_next               = 1'b1;
                state_next                   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cluster_reg   <= fcw_pkg::CLUSTER_END;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cluster_reg   <= cluster_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload of the step in work and of the waiting extent
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (step_live)
        begin
            offset_reg <= offset;
            odd_reg    <= cluster_reg[0];
            length_reg <= length;
        end
        if (state_reg == ST_RD_HI)
        begin
            low_byte_reg <= rd_data;
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg    <= '0;
            cluster_bytes_reg <= 17'd512;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcw_pkg::CFG_DATA_START: data_start_reg    <= cfg_data;
                fcw_pkg::CFG_CLUSTER:    cluster_bytes_reg <= cfg_data[fcw_pkg::EXTENT_W-1:0];
                default:                 data_start_reg    <= data_start_reg;
            endcase
        end
    end

    // A step keeps the block busy in the next cycle
    a_step_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (items.data.op == fcw_pkg::OP_STEP)) |=> !items.ready)
        else $error("item accepted right after a step");

    // An extent appears only after a step or the final sequencer state
    a_extent_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past(state_reg == ST_FIN || (accept && (items.data.op == fcw_pkg::OP_STEP))))
        else $error("extent without a step");

    // A bad cluster ends the chain with an empty extent
    a_bad_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.status == fcw_pkg::STATUS_BAD)) |->
            (out_item_reg.last && (out_item_reg.extent_length == '0)))
        else $error("bad cluster extent not terminal");

    // An extent never exceeds the largest cluster
    a_length_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.extent_length <= fcw_pkg::CLUSTER_BYTES_MAX))
        else $error("extent length above cluster size");

    // A finished chain stays finished until the next start
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((remaining_reg == '0) && !(accept && (items.data.op == fcw_pkg::OP_START))
            && (state_reg == ST_IDLE)) |=> (remaining_reg == '0))
        else $error("finished chain resumed without a start");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fat12_cluster_chain_walker_core. A generator builds
// FAT12 chains in the byte table, starts walks over them and steps them out.
// A driver feeds the items with random gaps, and a monitor takes the extents
// with random stalls. Each extent is checked field by field against a
// cycle-free model of the walker that runs on every accepted item.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int                       TABLE_BYTES = 6144;
    localparam int                       INDEX_TOP   = 8191;
    localparam logic [fcw_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                       MAX_REPORTS = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b1;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data  = '0;

    fcw_in_if  cmd_ch ();
    fcw_out_if ext_ch ();

    fat12_cluster_chain_walker_core #(
        .FAT_BYTES(TABLE_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .items(cmd_ch),
        .extents(ext_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Items waiting for the driver, extents waiting for the monitor
    fcw_pkg::in_item_t  cmd_queue [$];
    fcw_pkg::out_item_t extent_queue [$];
    int        issued_count   = 0;
    int        accepted_count = 0;
    int        phase_items    = 0;

    // Idle control for both sides
    int src_gap_pct   = 0;
    int snk_stall_pct = 0;
    int src_idle;
    int snk_idle;

    int mismatches  = 0;
    int extent_seen = 0;

    // Walker state as seen at item acceptance
    logic [31:0] cfg_data_start    = '0;
    logic [16:0] cfg_cluster_bytes = 17'd512;
    logic [7:0]  fat_bytes [TABLE_BYTES];
    logic [11:0] walk_cluster      = fcw_pkg::CLUSTER_END;
    logic [31:0] walk_left         = '0;

    // Walker state as seen at the tail of the pending list
    logic [7:0]  plan_bytes [TABLE_BYTES];
    bit          plan_loaded [TABLE_BYTES];
    logic [11:0] plan_cluster = fcw_pkg::CLUSTER_END;
    logic [31:0] plan_left    = '0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [16:0] cluster_span();
        return (cfg_cluster_bytes > fcw_pkg::CLUSTER_BYTES_MAX)
             ? fcw_pkg::CLUSTER_BYTES_MAX : cfg_cluster_bytes;
    endfunction

    function automatic bit is_bad_cluster(logic [11:0] cl);
        return (cl < 12'd2) || (cl == fcw_pkg::CLUSTER_BAD);
    endfunction

    function automatic int entry_offset(logic [11:0] cl);
        return (int'(cl) * 3) / 2;
    endfunction

    // Odd clusters take the high nibble of the first byte, even ones the low byte
    function automatic logic [11:0] unpack_entry(logic [11:0] cl, logic [7:0] lo, logic [7:0] hi);
        return cl[0] ? {hi, lo[7:4]} : {hi[3:0], lo};
    endfunction

    // Advance the walker on one accepted item and queue the extent it owes
    function automatic void predict_item(fcw_pkg::in_item_t it);
        fcw_pkg::out_item_t x;
        logic [16:0] span;
        logic [31:0] take;
        logic [11:0] nxt;
        int          off;
        x    = '0;
        span = cluster_span();
        case (it.op)
            fcw_pkg::OP_LOAD:
            begin
                if (it.table_index < TABLE_BYTES)
                    fat_bytes[it.table_index] = it.table_byte;
            end
            fcw_pkg::OP_START:
            begin
                walk_cluster = it.start_cluster;
                walk_left    = it.file_length;
            end
            fcw_pkg::OP_STEP:
            begin
                if (walk_left == 0 || walk_cluster >= fcw_pkg::CLUSTER_EOC_MIN)
                begin
                    x.status = fcw_pkg::STATUS_DONE;
                end
                else if (is_bad_cluster(walk_cluster))
                begin
                    x.last       = 1'b1;
                    x.status     = fcw_pkg::STATUS_BAD;
                    walk_cluster = fcw_pkg::CLUSTER_END;
                    walk_left    = '0;
                end
                else
                begin
                    off  = entry_offset(walk_cluster);
                    take = (32'(span) < walk_left) ? 32'(span) : walk_left;
                    nxt  = unpack_entry(walk_cluster, fat_bytes[off], fat_bytes[off + 1]);
                    x.extent_address = 33'(cfg_data_start)
                                     + 33'(span) * 33'(walk_cluster - 12'd2);
                    x.extent_length  = take[16:0];
                    walk_left        = walk_left - take;
                    walk_cluster     = nxt;
                    x.last   = (walk_left == 0) || (nxt >= fcw_pkg::CLUSTER_EOC_MIN)
                            || is_bad_cluster(nxt);
                    x.status = fcw_pkg::STATUS_OK;
                end
                extent_queue.push_back(x);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic fcw_pkg::in_item_t random_item(logic [fcw_pkg::OP_W-1:0] op);
        fcw_pkg::in_item_t it;
        it.op            = op;
        it.table_index   = 13'($urandom);
        it.table_byte    = 8'($urandom);
        it.start_cluster = 12'($urandom);
        it.file_length   = $urandom;
        return it;
    endfunction

    // Count only items that the walker acts on
    function automatic void push_item(fcw_pkg::in_item_t it);
        cmd_queue.push_back(it);
        issued_count++;
        if (it.op != OP_UNUSED
            && !(it.op == fcw_pkg::OP_LOAD && it.table_index >= TABLE_BYTES))
            phase_items++;
    endfunction

    function automatic void queue_load(int idx, logic [7:0] val);
        fcw_pkg::in_item_t it;
        it             = random_item(fcw_pkg::OP_LOAD);
        it.table_index = 13'(idx);
        it.table_byte  = val;
        if (idx < TABLE_BYTES)
        begin
            plan_bytes[idx]  = val;
            plan_loaded[idx] = 1'b1;
        end
        push_item(it);
    endfunction

    function automatic void queue_start(logic [11:0] cl, logic [31:0] len);
        fcw_pkg::in_item_t it;
        it               = random_item(fcw_pkg::OP_START);
        it.start_cluster = cl;
        it.file_length   = len;
        plan_cluster     = cl;
        plan_left        = len;
        push_item(it);
    endfunction

    // Load any table byte this step will read before the step goes out
    function automatic void queue_step();
        logic [31:0] take;
        int          off;
        if (plan_left != 0 && plan_cluster < fcw_pkg::CLUSTER_EOC_MIN
            && !is_bad_cluster(plan_cluster))
        begin
            off = entry_offset(plan_cluster);
            for (int k = off; k <= off + 1; k++)
            begin
                if (!plan_loaded[k])
                    queue_load(k, 8'($urandom));
            end
            take         = (32'(cluster_span()) < plan_left) ? 32'(cluster_span()) : plan_left;
            plan_left    = plan_left - take;
            plan_cluster = unpack_entry(plan_cluster, plan_bytes[off], plan_bytes[off + 1]);
        end
        else if (plan_left != 0 && plan_cluster < fcw_pkg::CLUSTER_EOC_MIN)
        begin
            plan_cluster = fcw_pkg::CLUSTER_END;
            plan_left    = '0;
        end
        push_item(random_item(fcw_pkg::OP_STEP));
    endfunction

    // Write one 12-bit entry, keeping the nibble it shares with its neighbor
    function automatic void set_entry(logic [11:0] cl, logic [11:0] val);
        logic [7:0] lo;
        logic [7:0] hi;
        int         off;
        off = entry_offset(cl);
        lo  = plan_loaded[off] ? plan_bytes[off] : 8'($urandom);
        hi  = plan_loaded[off + 1] ? plan_bytes[off + 1] : 8'($urandom);
        if (cl[0])
        begin
            lo[7:4] = val[3:0];
            hi      = val[11:4];
        end
        else
        begin
            lo      = val[7:0];
            hi[3:0] = val[11:8];
        end
        queue_load(off, lo);
        queue_load(off + 1, hi);
    endfunction

    function automatic void queue_noise();
        case ($urandom_range(3))
            0: push_item(random_item(OP_UNUSED));
            1: queue_load($urandom_range(0, INDEX_TOP), 8'($urandom));
            2: queue_start(12'($urandom), $urandom);
            default: queue_step();
        endcase
    endfunction

    // Start on an arbitrary cluster, marks included, and step a few times
    function automatic void queue_random_walk();
        logic [11:0] cl;
        logic [31:0] len;
        case ($urandom_range(3))
            0: cl = 12'($urandom);
            1: cl = 12'($urandom_range(2, 64));
            2:
            begin
                case ($urandom_range(5))
                    0: cl = 12'd0;
                    1: cl = 12'd1;
                    2: cl = fcw_pkg::CLUSTER_BAD;
                    3: cl = fcw_pkg::CLUSTER_BAD - 12'd1;
                    4: cl = fcw_pkg::CLUSTER_EOC_MIN;
                    default: cl = fcw_pkg::CLUSTER_END;
                endcase
            end
            default: cl = 12'($urandom_range(2, 400));
        endcase
        len = $urandom_range(1) ? $urandom : $urandom_range(0, 4 * int'(cluster_span()));
        queue_start(cl, len);
        repeat ($urandom_range(1, 6))
            queue_step();
    endfunction

    // Build a chain of distinct clusters, start it and step it out
    function automatic void queue_chain();
        logic [11:0] links [$];
        logic [11:0] cl;
        logic [11:0] tail;
        logic [31:0] len;
        bit          taken;
        int          n;
        longint      full;
        n = $urandom_range(1, 8);
        while (links.size() < n)
        begin
            cl = ($urandom_range(3) == 0)
               ? 12'($urandom_range(2, fcw_pkg::CLUSTER_BAD - 12'd1))
               : 12'($urandom_range(2, 300));
            taken = 1'b0;
            foreach (links[i])
            begin
                if (links[i] == cl)
                    taken = 1'b1;
            end
            if (!taken)
                links.push_back(cl);
        end
        case ($urandom_range(5))
            3: tail = fcw_pkg::CLUSTER_BAD;
            4: tail = 12'($urandom_range(1));
            5: tail = links[$urandom_range(0, n - 1)];
            default: tail = 12'($urandom_range(fcw_pkg::CLUSTER_EOC_MIN, fcw_pkg::CLUSTER_END));
        endcase
        for (int i = 0; i < n; i++)
            set_entry(links[i], (i + 1 < n) ? links[i + 1] : tail);
        full = longint'(cluster_span()) * n;
        case ($urandom_range(6))
            0: len = 32'(full);
            1: len = 32'(full) - 32'd1;
            2: len = 32'hFFFF_FFFF;
            3: len = $urandom;
            4: len = '0;
            default: len = $urandom_range(1, 32'(full) + 1);
        endcase
        queue_start(links[0], len);
        repeat (n + $urandom_range(0, 2))
        begin
            if ($urandom_range(9) == 0)
                queue_noise();
            queue_step();
        end
    endfunction

    // Hold until every item is taken and every extent checked, then let the
    // block finish a trailing load or start
    task automatic wait_idle();
        while (accepted_count != issued_count || extent_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == fcw_pkg::CFG_DATA_START)
            cfg_data_start = value;
        else
            cfg_cluster_bytes = value[16:0];
    endtask

    task automatic apply_setting(logic [31:0] base, logic [31:0] span, int gap, int stall);
        write_reg(fcw_pkg::CFG_DATA_START, base);
        write_reg(fcw_pkg::CFG_CLUSTER, span);
        src_gap_pct   = gap;
        snk_stall_pct = stall;
    endtask

    task automatic run_phase(int target);
        phase_items = 0;
        while (phase_items < target)
        begin
            case ($urandom_range(9))
                7: queue_random_walk();
                8, 9:
                begin
                    repeat ($urandom_range(1, 3))
                        queue_noise();
                end
                default: queue_chain();
            endcase
        end
        wait_idle();
    endtask

    // Feed items; predict each one at the edge that accepts it
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
            src_idle     <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_item(cmd_ch.data);
                accepted_count++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (src_idle != 0)
                begin
                    src_idle     <= src_idle - 1;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_queue.size() != 0)
                begin
                    cmd_ch.data  <= cmd_queue.pop_front();
                    cmd_ch.valid <= 1'b1;
                    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct)
                        src_idle <= $urandom_range(1, 11);
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Take extents with random stall bursts and check each one
    always @(posedge clk or negedge rst_n)
    begin : watch_extents
        fcw_pkg::out_item_t want;
        if (!rst_n)
        begin
            ext_ch.ready <= 1'b0;
            snk_idle     <= 0;
        end
        else
        begin
            if (ext_ch.valid && ext_ch.ready)
            begin
                extent_seen++;
                if (extent_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("extent %0d with nothing expected: ", extent_seen,
                                 "addr=%h len=%h last=%b status=%0d",
                                 ext_ch.data.extent_address,
                                 ext_ch.data.extent_length, ext_ch.data.last,
                                 ext_ch.data.status);
                end
                else
                begin
                    want = extent_queue.pop_front();
                    if (ext_ch.data.extent_address !== want.extent_address
                        || ext_ch.data.extent_length !== want.extent_length
                        || ext_ch.data.last !== want.last
                        || ext_ch.data.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("extent %0d: expected ", extent_seen,
                                     "addr=%h len=%h last=%b status=%0d, ",
                                     want.extent_address, want.extent_length,
                                     want.last, want.status,
                                     "got addr=%h len=%h last=%b status=%0d",
                                     ext_ch.data.extent_address,
                                     ext_ch.data.extent_length, ext_ch.data.last,
                                     ext_ch.data.status);
                    end
                end
            end
            if (snk_idle != 0)
            begin
                snk_idle     <= snk_idle - 1;
                ext_ch.ready <= 1'b0;
            end
            else if (snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct)
            begin
                snk_idle     <= $urandom_range(10);
                ext_ch.ready <= 1'b0;
            end
            else
            begin
                ext_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        src_gap_pct   = 25;
        snk_stall_pct = 5;

        // Step the chain left finished by reset, then ignored items
        queue_step();
        push_item(random_item(OP_UNUSED));
        queue_load(TABLE_BYTES, 8'hFF);
        queue_load(INDEX_TOP, 8'h00);
        // Two clusters, even entry then odd entry, file ends inside the second
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, fcw_pkg::CLUSTER_END);
        queue_start(12'd2, 32'd1000);
        repeat (3) queue_step();
        // Bad cluster numbers end the chain
        queue_start(12'd0, 32'd5);
        queue_step();
        queue_step();
        queue_start(12'd1, 32'hFFFF_FFFF);
        queue_step();
        queue_start(fcw_pkg::CLUSTER_BAD, 32'd1);
        queue_step();
        // Empty file and an end mark as first cluster
        queue_start(12'd2, 32'd0);
        queue_step();
        queue_start(fcw_pkg::CLUSTER_EOC_MIN, 32'd7);
        queue_step();
        // Highest usable cluster, pointing at the bad mark
        set_entry(fcw_pkg::CLUSTER_BAD - 12'd1, fcw_pkg::CLUSTER_BAD);
        queue_start(fcw_pkg::CLUSTER_BAD - 12'd1, 32'hFFFF_FFFF);
        queue_step();
        queue_step();
        wait_idle();

        run_phase(220);
        apply_setting(32'hFFFF_FFFF, 32'h0001_0000, 40, 10);
        run_phase(250);
        apply_setting(32'h0000_0000, 32'd1, 10, 15);
        run_phase(250);
        apply_setting($urandom, 32'd0, 30, 3);
        run_phase(250);
        apply_setting($urandom, 32'h0001_FFFF, 15, 8);
        run_phase(250);
        apply_setting(32'hFFFF_FFFF, $urandom_range(1, 4096), 20, 5);
        run_phase(250);
        // Last stretch runs with no gaps and no stalls
        apply_setting($urandom, $urandom_range(1, 65536), 0, 0);
        run_phase(250);

        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("fat12_cluster_chain_walker_core: match");
        else
            $display("fat12_cluster_chain_walker_core: mismatch");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("fat12_cluster_chain_walker_core: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hdl/fcw_pkg.sv
hdl/fcw_channels.sv
hdl/fcw_fat_ram.sv
hdl/fcw_addr_unit.sv
hdl/fat12_cluster_chain_walker_core.sv
sim/tb_top.sv
